// File: hw/rtl/scavg_pkg.sv
// Shared types and constants of the sorted cluster average block.
package scavg_pkg;

	localparam int SAMPLE_W = 34;
	localparam int TOL_W    = 32;
	localparam int TARGET_W = 5;
	localparam int SUM_W    = 39;
	localparam int TDATA_W  = 40;
	localparam int DCNT_W   = 6;

	localparam logic [TOL_W-1:0]    TOL_RESET    = 32'd50000;
	localparam logic [TARGET_W-1:0] TARGET_RESET = 5'd3;

	// Configuration register indexes.
	localparam logic REG_TOLERANCE  = 1'b0;
	localparam logic REG_RUN_TARGET = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the accepted item
		logic ins_rd;     // read the entry just below the insert slot
		logic ins_shift;  // move the read entry up one slot
		logic ins_put;    // write the new sample into the insert slot
		logic sc_init;    // clear the run and read the smallest sample
		logic sc_first;   // take the smallest sample as the previous one
		logic sc_rd;      // read the next sorted sample
		logic sc_pair;    // judge one neighbor pair
		logic su_issue;   // start reading the run's samples
		logic su_acc;     // add one run sample
		logic div_step;   // one step of the mean divider
		logic out_load;   // load the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic last;
		logic i_zero;
		logic i_one;
		logic gt;
		logic more_first;
		logic more_pair;
		logic len_zero;
		logic su_done;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage

// File: hw/rtl/scavg_ram.sv
// Generic single write port, single read port RAM with registered read data.
module scavg_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/scavg_ctrl.sv
// Controller state machine of the sorted cluster average block.
module scavg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  scavg_pkg::sts_t   sts,
	output scavg_pkg::cmd_t   cmd
);

	import scavg_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b000_0000_0001,
		ST_INS      = 11'b000_0000_0010,
		ST_INS_CMP  = 11'b000_0000_0100,
		ST_INS_PUT  = 11'b000_0000_1000,
		ST_SC_INIT  = 11'b000_0001_0000,
		ST_SC_FIRST = 11'b000_0010_0000,
		ST_SC_PAIR  = 11'b000_0100_0000,
		ST_SU_ISSUE = 11'b000_1000_0000,
		ST_SU_ACC   = 11'b001_0000_0000,
		ST_DIV      = 11'b010_0000_0000,
		ST_OUT      = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t after_ins;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign after_ins = sts.last ? ST_SC_INIT : ST_IDLE;
	assign s_tready  = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_INS;
				end
			end
			ST_INS: begin
				if (sts.full) begin
					state_d = after_ins;
				end else if (sts.i_zero) begin
					cmd.ins_put = 1'b1;
					state_d     = after_ins;
				end else begin
					cmd.ins_rd = 1'b1;
					state_d    = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				if (sts.gt) begin
					cmd.ins_shift = 1'b1;
					state_d       = sts.i_one ? ST_INS_PUT : ST_INS_CMP;
				end else begin
					cmd.ins_put = 1'b1;
					state_d     = after_ins;
				end
			end
			ST_INS_PUT: begin
				cmd.ins_put = 1'b1;
				state_d     = after_ins;
			end
			ST_SC_INIT: begin
				cmd.sc_init = 1'b1;
				state_d     = ST_SC_FIRST;
			end
			ST_SC_FIRST: begin
				cmd.sc_first = 1'b1;
				if (sts.more_first) begin
					cmd.sc_rd = 1'b1;
					state_d   = ST_SC_PAIR;
				end else begin
					state_d = ST_SU_ISSUE;
				end
			end
			ST_SC_PAIR: begin
				cmd.sc_pair = 1'b1;
				if (sts.more_pair) begin
					cmd.sc_rd = 1'b1;
				end else begin
					state_d = ST_SU_ISSUE;
				end
			end
			ST_SU_ISSUE: begin
				if (sts.len_zero) begin
					state_d = ST_OUT;
				end else begin
					cmd.su_issue = 1'b1;
					state_d      = ST_SU_ACC;
				end
			end
			ST_SU_ACC: begin
				cmd.su_acc = 1'b1;
				if (sts.su_done) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> s_tready)
		else $error("item captured outside idle");

	a_no_input_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !s_tready)
		else $error("ready stayed high after an item was taken");

	a_div_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && sts.div_done) |=> (state_q == ST_OUT))
		else $error("divider finish did not lead to the output state");

endmodule

// File: hw/rtl/scavg_dpath.sv
// Datapath of the sorted cluster average block: sample store, scan, sum and divider.
module scavg_dpath #(
	parameter int MAX_SAMPLES = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  scavg_pkg::cmd_t                       cmd,
	output scavg_pkg::sts_t                       sts,
	input  logic [scavg_pkg::SAMPLE_W-1:0]        in_sample,
	input  logic                                  in_last,
	input  logic                                  cfg_we,
	input  logic                                  cfg_index,
	input  logic [scavg_pkg::TOL_W-1:0]           cfg_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  out_found,
	output logic [scavg_pkg::SAMPLE_W-1:0]        out_average
);

	import scavg_pkg::*;

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	logic [TOL_W-1:0]    tol_q;
	logic [TARGET_W-1:0] tgt_q;

	logic [SAMPLE_W-1:0] v_q;
	logic                last_q;
	logic [CW-1:0]       i_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       k_q;
	logic [SAMPLE_W-1:0] prev_q;
	logic [TARGET_W-1:0] len_q;
	logic [AW-1:0]       start_q;
	logic                runv_q;
	logic [SUM_W-1:0]    sum_q;
	logic [AW-1:0]       ra_q;
	logic [TARGET_W-1:0] acc_cnt_q;
	logic [TARGET_W-1:0] rem_q;
	logic [DCNT_W-1:0]   dcnt_q;

	logic [CW-1:0]       im1;
	logic [CW-1:0]       im2;
	logic [CW-1:0]       km2;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       waddr;
	logic [SAMPLE_W-1:0] wdata;
	logic                we;
	logic [SAMPLE_W-1:0] rdata;
	logic [SAMPLE_W-1:0] diff;
	logic                close;
	logic [TARGET_W-1:0] len_nxt;
	logic [TARGET_W:0]   shifted;
	logic                ge;

	assign im1 = i_q - CW'(1);
	assign im2 = i_q - CW'(2);
	assign km2 = k_q - CW'(2);

	always_comb begin
		raddr = '0;
		if (cmd.ins_rd) begin
			raddr = im1[AW-1:0];
		end else if (cmd.ins_shift) begin
			raddr = im2[AW-1:0];
		end else if (cmd.sc_rd) begin
			raddr = k_q[AW-1:0];
		end else if (cmd.su_issue) begin
			raddr = start_q;
		end else if (cmd.su_acc) begin
			raddr = ra_q;
		end
	end

	assign we    = cmd.ins_shift | cmd.ins_put;
	assign waddr = i_q[AW-1:0];
	assign wdata = cmd.ins_shift ? rdata : v_q;

	scavg_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign diff    = rdata - prev_q;
	assign close   = (diff <= {{(SAMPLE_W-TOL_W){1'b0}}, tol_q});
	assign len_nxt = close ? (len_q + TARGET_W'(1)) : '0;
	assign shifted = {rem_q, sum_q[SUM_W-1]};
	assign ge      = (shifted >= {1'b0, len_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
			tgt_q <= TARGET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOLERANCE:  tol_q <= cfg_data;
				REG_RUN_TARGET: tgt_q <= cfg_data[TARGET_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			len_q     <= '0;
			runv_q    <= 1'b0;
			sum_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.ins_put) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.sc_init) begin
				len_q  <= '0;
				runv_q <= 1'b0;
				sum_q  <= '0;
			end
			if (cmd.sc_pair) begin
				len_q  <= len_nxt;
				runv_q <= close;
			end
			if (cmd.su_acc) begin
				sum_q <= sum_q + {{(SUM_W-SAMPLE_W){1'b0}}, rdata};
			end
			if (cmd.div_step) begin
				sum_q <= {sum_q[SUM_W-2:0], ge};
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
				count_q   <= '0;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q    <= in_sample;
			last_q <= in_last;
			i_q    <= count_q;
		end
		if (cmd.ins_shift) begin
			i_q <= im1;
		end
		if (cmd.sc_init) begin
			k_q <= CW'(1);
		end
		if (cmd.sc_first || cmd.sc_pair) begin
			prev_q <= rdata;
		end
		if (cmd.sc_rd) begin
			k_q <= k_q + CW'(1);
		end
		if (cmd.sc_pair && close && !runv_q) begin
			start_q <= km2[AW-1:0];
		end
		if (cmd.su_issue) begin
			ra_q      <= start_q + AW'(1);
			acc_cnt_q <= '0;
			rem_q     <= '0;
			dcnt_q    <= '0;
		end
		if (cmd.su_acc) begin
			ra_q      <= ra_q + AW'(1);
			acc_cnt_q <= acc_cnt_q + TARGET_W'(1);
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? TARGET_W'(shifted - {1'b0, len_q}) : shifted[TARGET_W-1:0];
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
		if (cmd.out_load) begin
			out_found   <= (len_q != '0);
			out_average <= sum_q[SAMPLE_W-1:0];
		end
	end

	always_comb begin
		sts.full       = (count_q == CW'(MAX_SAMPLES));
		sts.last       = last_q;
		sts.i_zero     = (i_q == '0);
		sts.i_one      = (i_q == CW'(1));
		sts.gt         = (rdata > v_q);
		sts.more_first = (k_q < count_q) && (len_q < tgt_q);
		sts.more_pair  = (k_q < count_q) && (len_nxt < tgt_q);
		sts.len_zero   = (len_q == '0);
		sts.su_done    = ((acc_cnt_q + TARGET_W'(1)) == len_q);
		sts.div_done   = (dcnt_q == DCNT_W'(SUM_W - 1));
		sts.out_busy   = out_valid && !out_ready;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SAMPLES))
		else $error("sample count beyond store depth");

	a_run_flag: assert property (@(posedge clk) disable iff (!arst_n)
		runv_q == (len_q != '0))
		else $error("run start flag disagrees with run length");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && !out_ready))
		else $error("result register overwritten while held");

	a_out_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("result not presented after load");

endmodule

// File: hw/rtl/sorted_cluster_average.sv
// Top level of the sorted cluster average block.
//
// The block collects a batch of rate samples, one item per sample, keeping
// them sorted ascending in a single-port-write RAM of MAX_SAMPLES entries by
// insertion. When an item arrives with tlast set, adjacent sorted pairs are
// scanned from the smallest upward; a pair whose gap is at most tolerance
// extends the current run, a larger gap ends it, and the scan stops once the
// run holds run_target pairs or the pairs are used up. The block then emits
// one result item: tuser is 1 when a run was found and tdata carries the
// truncated mean of run-length samples starting at the run start; with no
// run, tuser and tdata are zero. Samples that arrive while the store is full
// are dropped, though a dropped sample carrying tlast still closes the batch.
// Items are taken one at a time. A sample without tlast occupies the block
// while the insertion moves each stored sample larger than it up one slot,
// one RAM entry per cycle through its one write port. A sample with tlast
// adds the scan of neighbor pairs, the run sum, a restoring divider for the
// mean and the load of the output register, which waits while a previous
// result is still held. When no run is found no run samples are summed and
// the divider is skipped. The result sits in that register until taken, and
// the block accepts the next item only once the result register has been
// loaded.
// Configuration writes are taken on any cycle the enable is high and must
// only be issued while the block is idle.
module sorted_cluster_average #(
	parameter int MAX_SAMPLES = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Sample stream.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [scavg_pkg::TDATA_W-1:0]        s_tdata,   // [33:0] sample, rest zero
	input  logic                                 s_tlast,   // last sample of the batch
	// Result stream.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [scavg_pkg::TDATA_W-1:0]        m_tdata,   // [33:0] average, rest zero
	output logic                                 m_tuser,   // [0] found
	// Configuration write port.
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [scavg_pkg::TOL_W-1:0]          cfg_data
);

	import scavg_pkg::*;

	cmd_t                cmd;
	sts_t                sts;
	logic [SAMPLE_W-1:0] average;

	// The controller sequences insertion, scan, sum, divide and output.
	scavg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the store, configuration, run state and result register.
	scavg_dpath #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_sample   (s_tdata[SAMPLE_W-1:0]),
		.in_last     (s_tlast),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_found   (m_tuser),
		.out_average (average)
	);

	// The upper tdata bits are padding to whole bytes.
	assign m_tdata = {{(TDATA_W-SAMPLE_W){1'b0}}, average};

endmodule
